// ----- rtl/core/wsrb_pkg.sv -----
// Package for the windowed sort release buffer: sizes, entry type,
// sequencer states and the cell and sequencer control structs. No dependencies.
`timescale 1ns / 1ps

package wsrb_pkg;

   localparam int DEPTH     = 32;
   localparam int GRP_W     = 16;
   localparam int POS_W     = 31;
   localparam int TAG_W     = 32;
   localparam int WINDOW_W  = 31;

   localparam logic        ACT_INSERT = 1'b0;
   localparam logic        ACT_FLUSH  = 1'b1;
   localparam logic [POS_W-1:0] CUTOFF_MIN = POS_W'(1);

   typedef struct packed {
      logic [GRP_W-1:0] grp;
      logic [POS_W-1:0] pos;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_INSERT
   } cell_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_EMIT_FULL,
      ST_INSERT,
      ST_CUT,
      ST_RELEASE,
      ST_DONE
   } state_type;

   // status seen by the sequencer
   typedef struct packed {
      logic flush;
      logic empty;
      logic full;
      logic grp_diff;
      logic rel_hit;
   } status_type;

   // strobes from the sequencer to the datapath
   typedef struct packed {
      cell_cmd_type cmd;
      logic         latch;
      logic         emit;
      logic         ins;
      logic         cut;
      logic         finish;
   } ctrl_type;

endpackage

// ----- rtl/core/wsrb_cell.sv -----
// One slot of the sorted chain: holds an entry and its valid bit.
// Depends on wsrb_pkg.
`timescale 1ns / 1ps

module wsrb_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  wsrb_pkg::cell_cmd_type cmd,
   input  wsrb_pkg::entry_type   new_ent,
   input  logic                  left_place,
   input  logic                  left_valid,
   input  wsrb_pkg::entry_type   left_ent,
   input  logic                  right_valid,
   input  wsrb_pkg::entry_type   right_ent,
   output logic                  valid,
   output wsrb_pkg::entry_type   ent,
   output logic                  place
);

   logic                valid_ff, valid_in;
   wsrb_pkg::entry_type ent_ff, ent_in;

   // strictly greater keeps equal keys in arrival order
   assign place = !valid_ff || (ent_ff.pos > new_ent.pos);

   always_comb begin
      valid_in = valid_ff;
      ent_in   = ent_ff;
      unique case (cmd)
         wsrb_pkg::CELL_SHIFT: begin
            valid_in = right_valid;
            ent_in   = right_ent;
         end
         wsrb_pkg::CELL_INSERT: begin
            if (left_place) begin
               valid_in = left_valid;
               ent_in   = left_ent;
            end else if (place) begin
               valid_in = 1'b1;
               ent_in   = new_ent;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      ent_ff <= ent_in;
   end

   assign valid = valid_ff;
   assign ent   = ent_ff;

endmodule

// ----- rtl/core/wsrb_ctrl.sv -----
// Sequencer of the buffer: steps each command word through drain, full-buffer emit,
// insert, cutoff and release phases. Depends on wsrb_pkg.
`timescale 1ns / 1ps

module wsrb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  wsrb_pkg::status_type stat,
   output logic                busy,
   output wsrb_pkg::ctrl_type  ctl
);

   wsrb_pkg::state_type state_ff, state_in;
   logic ins_pend_ff, ins_pend_in;
   logic check_ff, check_in;

   always_comb begin
      state_in    = state_ff;
      ins_pend_in = ins_pend_ff;
      check_in    = check_ff;
      unique case (state_ff)
         wsrb_pkg::ST_IDLE: begin
            if (start) begin
               ins_pend_in = 1'b0;
               check_in    = 1'b0;
               if (stat.flush) begin
                  state_in = wsrb_pkg::ST_DRAIN;
               end else if (stat.empty) begin
                  state_in = wsrb_pkg::ST_INSERT;
               end else if (stat.grp_diff) begin
                  state_in    = wsrb_pkg::ST_DRAIN;
                  ins_pend_in = 1'b1;
               end else if (stat.full) begin
                  state_in = wsrb_pkg::ST_EMIT_FULL;
                  check_in = 1'b1;
               end else begin
                  state_in = wsrb_pkg::ST_INSERT;
                  check_in = 1'b1;
               end
            end
         end
         wsrb_pkg::ST_DRAIN: begin
            if (stat.empty) begin
               state_in = ins_pend_ff ? wsrb_pkg::ST_INSERT : wsrb_pkg::ST_DONE;
            end
         end
         wsrb_pkg::ST_EMIT_FULL: state_in = wsrb_pkg::ST_INSERT;
         wsrb_pkg::ST_INSERT: begin
            state_in = check_ff ? wsrb_pkg::ST_CUT : wsrb_pkg::ST_DONE;
         end
         wsrb_pkg::ST_CUT:     state_in = wsrb_pkg::ST_RELEASE;
         wsrb_pkg::ST_RELEASE: begin
            if (!stat.rel_hit) begin
               state_in = wsrb_pkg::ST_DONE;
            end
         end
         wsrb_pkg::ST_DONE:    state_in = wsrb_pkg::ST_IDLE;
         default:              state_in = wsrb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl        = '0;
      ctl.cmd    = wsrb_pkg::CELL_HOLD;
      busy       = 1'b1;
      unique case (state_ff)
         wsrb_pkg::ST_IDLE: begin
            busy      = 1'b0;
            ctl.latch = start;
         end
         wsrb_pkg::ST_DRAIN: begin
            if (!stat.empty) begin
               ctl.cmd  = wsrb_pkg::CELL_SHIFT;
               ctl.emit = 1'b1;
            end
         end
         wsrb_pkg::ST_EMIT_FULL: begin
            ctl.cmd  = wsrb_pkg::CELL_SHIFT;
            ctl.emit = 1'b1;
         end
         wsrb_pkg::ST_INSERT: begin
            ctl.cmd = wsrb_pkg::CELL_INSERT;
            ctl.ins = 1'b1;
         end
         wsrb_pkg::ST_CUT: ctl.cut = 1'b1;
         wsrb_pkg::ST_RELEASE: begin
            if (stat.rel_hit) begin
               ctl.cmd  = wsrb_pkg::CELL_SHIFT;
               ctl.emit = 1'b1;
            end
         end
         wsrb_pkg::ST_DONE: ctl.finish = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= wsrb_pkg::ST_IDLE;
         ins_pend_ff <= 1'b0;
         check_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ins_pend_ff <= ins_pend_in;
         check_ff    <= check_in;
      end
   end

endmodule

// ----- rtl/core/windowed_sort_release_buffer_core.sv -----
// Top level of the windowed sort release buffer: chain of wsrb_cell slots,
// the wsrb_ctrl sequencer, window register and output stage. Uses wsrb_pkg.
`timescale 1ns / 1ps

// Command word in on start while busy is low; busy then stays high until the
// word is fully handled. Results come out one word per cycle at most, each
// on rsp_valid for exactly one cycle, and the receiver cannot stall them, so
// it must take every strobe. rsp_last marks the final result of a command.
// How long busy lasts is set by the shift of the cell chain: one record leaves
// the chain per cycle, and the release cutoff is worked out in a state of its
// own after the insert. The last result is on the ports in the first cycle
// with busy low again. The user must write the window through csr_we only
// while the block is idle; the block itself does not enforce this.
module windowed_sort_release_buffer_core (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [wsrb_pkg::GRP_W-1:0]    req_group_id,
   input  logic [wsrb_pkg::POS_W-1:0]    req_position,
   input  logic [wsrb_pkg::TAG_W-1:0]    req_record_tag,
   // result channel
   output logic                          rsp_valid,
   output logic [wsrb_pkg::GRP_W-1:0]    rsp_group_id_out,
   output logic [wsrb_pkg::POS_W-1:0]    rsp_position_out,
   output logic [wsrb_pkg::TAG_W-1:0]    rsp_tag_out,
   output logic                          rsp_last,
   // window register
   input  logic                          csr_we,
   input  logic [wsrb_pkg::WINDOW_W-1:0] csr_wdata
);

   localparam int D = wsrb_pkg::DEPTH;

   wsrb_pkg::status_type stat;
   wsrb_pkg::ctrl_type   ctl;

   // window register
   logic [wsrb_pkg::WINDOW_W-1:0] window_ff;

   // latched command word
   wsrb_pkg::entry_type        new_ff;

   logic [wsrb_pkg::GRP_W-1:0] cur_group_ff;
   logic [wsrb_pkg::POS_W-1:0] max_ff, max_in;
   logic [wsrb_pkg::POS_W-1:0] cutoff_ff, cutoff_in;
   logic [wsrb_pkg::POS_W:0]   diff;

   // held result: goes out once we know whether another follows
   logic                       pend_v_ff, pend_v_in;
   wsrb_pkg::entry_type        pend_ff, pend_in;

   // output stage
   logic                       out_v_ff, out_v_in;
   logic                       out_last_ff, out_last_in;
   wsrb_pkg::entry_type        out_ff, out_in;

   // chain wiring
   logic                valid_w [D];
   logic                place_w [D];
   wsrb_pkg::entry_type ent_w   [D];

   genvar gi;
   generate
      for (gi = 0; gi < D; gi++) begin : g_cell
         logic                lp, lv, rv;
         wsrb_pkg::entry_type le, re;
         if (gi == 0) begin : g_first
            assign lp = 1'b0;
            assign lv = 1'b0;
            assign le = '0;
         end else begin : g_mid
            assign lp = place_w[gi-1];
            assign lv = valid_w[gi-1];
            assign le = ent_w[gi-1];
         end
         if (gi == D-1) begin : g_end
            assign rv = 1'b0;
            assign re = '0;
         end else begin : g_body
            assign rv = valid_w[gi+1];
            assign re = ent_w[gi+1];
         end
         wsrb_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (ctl.cmd),
            .new_ent     (new_ff),
            .left_place  (lp),
            .left_valid  (lv),
            .left_ent    (le),
            .right_valid (rv),
            .right_ent   (re),
            .valid       (valid_w[gi]),
            .ent         (ent_w[gi]),
            .place       (place_w[gi])
         );
      end
   endgenerate

   // valid bits form a prefix, so the end cells tell fill state
   always_comb begin
      stat.flush    = (req_action == wsrb_pkg::ACT_FLUSH);
      stat.empty    = !valid_w[0];
      stat.full     = valid_w[D-1];
      stat.grp_diff = (req_group_id != cur_group_ff);
      // release keeps one record back, so a second one must be there
      stat.rel_hit  = valid_w[1] && (ent_w[0].pos < cutoff_ff);
   end

   wsrb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .ctl   (ctl)
   );

   // largest buffered position: only the front ever leaves while records
   // remain, so a running maximum is enough; an empty chain restarts it
   always_comb begin
      max_in = max_ff;
      if (ctl.ins) begin
         if (stat.empty || (new_ff.pos > max_ff)) begin
            max_in = new_ff.pos;
         end
      end
   end

   // cutoff = max(largest - window, 1), no wrap
   assign diff = {1'b0, max_ff} - {1'b0, window_ff};
   always_comb begin
      cutoff_in = cutoff_ff;
      if (ctl.cut) begin
         if (diff[wsrb_pkg::POS_W] || (diff[wsrb_pkg::POS_W-1:0] == '0)) begin
            cutoff_in = wsrb_pkg::CUTOFF_MIN;
         end else begin
            cutoff_in = diff[wsrb_pkg::POS_W-1:0];
         end
      end
   end

   // each emitted record waits in the hold slot; the next emit pushes it out
   // as not-last, the end of the command pushes it out as last
   always_comb begin
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      out_v_in    = 1'b0;
      out_last_in = 1'b0;
      out_in      = pend_ff;
      if (ctl.emit) begin
         out_v_in  = pend_v_ff;
         pend_v_in = 1'b1;
         pend_in   = ent_w[0];
      end else if (ctl.finish) begin
         out_v_in    = pend_v_ff;
         out_last_in = pend_v_ff;
         pend_v_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         cur_group_ff <= '0;
         pend_v_ff    <= 1'b0;
         out_v_ff     <= 1'b0;
         out_last_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            window_ff <= csr_wdata;
         end
         if (ctl.ins) begin
            cur_group_ff <= new_ff.grp;
         end
         pend_v_ff   <= pend_v_in;
         out_v_ff    <= out_v_in;
         out_last_ff <= out_last_in;
      end
      if (ctl.latch) begin
         new_ff.grp <= req_group_id;
         new_ff.pos <= req_position;
         new_ff.tag <= req_record_tag;
      end
      max_ff    <= max_in;
      cutoff_ff <= cutoff_in;
      pend_ff   <= pend_in;
      out_ff    <= out_in;
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_group_id_out = out_ff.grp;
   assign rsp_position_out = out_ff.pos;
   assign rsp_tag_out      = out_ff.tag;

endmodule

// ----- rtl/core/wsrb_checker.sv -----
// Port-level checks of the windowed sort release buffer, bound to the top.
// Depends on windowed_sort_release_buffer_core.
`timescale 1ns / 1ps

module wsrb_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last
);

   // an accepted word always raises busy on the following cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after accepted word");

   // results only follow cycles of work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without preceding busy cycle");

   // idle with no new word yields no result next cycle
   a_quiet_idle: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !rsp_valid)
      else $error("result word while idle");

   // last only on a real result
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid)
      else $error("rsp_last without rsp_valid");

   // nothing straight out of reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result word right after reset");

endmodule

bind windowed_sort_release_buffer_core wsrb_checker u_wsrb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_last  (rsp_last)
);

// ----- sim/tb_windowed_sort_release_buffer_core.sv -----
// Self-checking bench for windowed_sort_release_buffer_core: directed and random command
// words, window rewrites between phases, every released record checked in order.
// Depends on wsrb_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_windowed_sort_release_buffer_core;

   typedef enum logic [1:0] {
      STEP_WORD,
      STEP_WINDOW,
      STEP_DRAIN
   } step_kind_type;

   typedef struct {
      step_kind_type                 kind;
      logic                          action;
      logic [wsrb_pkg::GRP_W-1:0]    grp;
      logic [wsrb_pkg::POS_W-1:0]    pos;
      logic [wsrb_pkg::TAG_W-1:0]    tag;
      logic [wsrb_pkg::WINDOW_W-1:0] window;
   } step_type;

   typedef struct packed {
      wsrb_pkg::entry_type rec;
      logic                last;
   } release_type;

   localparam int QUIET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_ITEMS   = 40;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          start          = 1'b0;
   logic                          busy;
   logic                          req_action     = wsrb_pkg::ACT_INSERT;
   logic [wsrb_pkg::GRP_W-1:0]    req_group_id   = '0;
   logic [wsrb_pkg::POS_W-1:0]    req_position   = '0;
   logic [wsrb_pkg::TAG_W-1:0]    req_record_tag = '0;
   logic                          rsp_valid;
   logic [wsrb_pkg::GRP_W-1:0]    rsp_group_id_out;
   logic [wsrb_pkg::POS_W-1:0]    rsp_position_out;
   logic [wsrb_pkg::TAG_W-1:0]    rsp_tag_out;
   logic                          rsp_last;
   logic                          csr_we         = 1'b0;
   logic [wsrb_pkg::WINDOW_W-1:0] csr_wdata      = '0;

   // sorted-buffer model
   wsrb_pkg::entry_type           sorted_recs[$];
   logic [wsrb_pkg::GRP_W-1:0]    held_group   = '0;
   logic [wsrb_pkg::WINDOW_W-1:0] model_window = '0;

   release_type         expected_releases[$];
   step_type            pending_steps[$];
   int                  errors    = 0;
   int                  gap_left  = 0;
   int                  quiet     = 0;
   logic                calm      = 1'b0;

   windowed_sort_release_buffer_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_group_id     (req_group_id),
      .req_position     (req_position),
      .req_record_tag   (req_record_tag),
      .rsp_valid        (rsp_valid),
      .rsp_group_id_out (rsp_group_id_out),
      .rsp_position_out (rsp_position_out),
      .rsp_tag_out      (rsp_tag_out),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void release_smallest();
      release_type r;
      r.rec  = sorted_recs[0];
      r.last = 1'b0;
      expected_releases.insert(expected_releases.size(), r);
      sorted_recs.delete(0);
   endfunction

   // stable insert: equal positions go behind those already held
   function automatic void store_sorted(wsrb_pkg::entry_type e);
      int i;
      i = sorted_recs.size();
      while (i > 0 && sorted_recs[i-1].pos > e.pos)
         i--;
      sorted_recs.insert(i, e);
   endfunction

   function automatic void predict_word(logic act, logic [wsrb_pkg::GRP_W-1:0] g,
                                        logic [wsrb_pkg::POS_W-1:0] p,
                                        logic [wsrb_pkg::TAG_W-1:0] t);
      wsrb_pkg::entry_type e;
      int                  emitted;
      longint              cutoff;
      e.grp   = g;
      e.pos   = p;
      e.tag   = t;
      emitted = 0;
      if (act == wsrb_pkg::ACT_FLUSH) begin
         while (sorted_recs.size() > 0) begin
            release_smallest();
            emitted++;
         end
      end else if (sorted_recs.size() == 0) begin
         store_sorted(e);
         held_group = g;
      end else if (g != held_group) begin
         while (sorted_recs.size() > 0) begin
            release_smallest();
            emitted++;
         end
         store_sorted(e);
         held_group = g;
      end else begin
         if (sorted_recs.size() >= wsrb_pkg::DEPTH) begin
            release_smallest();
            emitted++;
         end
         store_sorted(e);
         if (sorted_recs.size() >= 2) begin
            cutoff = longint'(sorted_recs[sorted_recs.size()-1].pos) - longint'(model_window);
            if (cutoff < 1)
               cutoff = 1;
            // one record always stays behind
            while (sorted_recs.size() > 1 && longint'(sorted_recs[0].pos) < cutoff) begin
               release_smallest();
               emitted++;
            end
         end
      end
      if (emitted > 0)
         expected_releases[expected_releases.size()-1].last = 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic void add_word(logic act, logic [wsrb_pkg::GRP_W-1:0] g,
                                    logic [wsrb_pkg::POS_W-1:0] p,
                                    logic [wsrb_pkg::TAG_W-1:0] t);
      step_type s;
      s.kind   = STEP_WORD;
      s.action = act;
      s.grp    = g;
      s.pos    = p;
      s.tag    = t;
      s.window = '0;
      pending_steps.insert(pending_steps.size(), s);
   endfunction

   function automatic void add_window(logic [wsrb_pkg::WINDOW_W-1:0] w);
      step_type s;
      s.kind   = STEP_WINDOW;
      s.action = wsrb_pkg::ACT_INSERT;
      s.grp    = '0;
      s.pos    = '0;
      s.tag    = '0;
      s.window = w;
      pending_steps.insert(pending_steps.size(), s);
   endfunction

   function automatic void add_drain();
      step_type s;
      s.kind   = STEP_DRAIN;
      s.action = wsrb_pkg::ACT_INSERT;
      s.grp    = '0;
      s.pos    = '0;
      s.tag    = '0;
      s.window = '0;
      pending_steps.insert(pending_steps.size(), s);
   endfunction

   // driver: one word at a time, window writes only once the block is quiet
   always @(posedge clock) begin : drive_p
      logic     nx_start;
      logic     nx_we;
      step_type s;
      if (reset) begin
         start  <= 1'b0;
         csr_we <= 1'b0;
         quiet  = 0;
      end else begin
         nx_start = start;
         nx_we    = 1'b0;
         if (start && !busy) begin
            predict_word(req_action, req_group_id, req_position, req_record_tag);
            nx_start = 1'b0;
            if ($urandom_range(0, 39) == 0)
               calm = !calm;
            gap_left = pick_gap();
         end
         if (busy || start || csr_we || expected_releases.size() != 0)
            quiet = 0;
         else
            quiet++;
         if (!nx_start && pending_steps.size() != 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               s = pending_steps[0];
               case (s.kind)
                  STEP_WORD: begin
                     req_action     <= s.action;
                     req_group_id   <= s.grp;
                     req_position   <= s.pos;
                     req_record_tag <= s.tag;
                     nx_start = 1'b1;
                     pending_steps.delete(0);
                  end
                  STEP_WINDOW: begin
                     if (quiet >= QUIET_CYCLES) begin
                        csr_wdata    <= s.window;
                        nx_we        = 1'b1;
                        model_window = s.window;
                        quiet        = 0;
                        pending_steps.delete(0);
                     end
                  end
                  default: begin
                     if (quiet >= QUIET_CYCLES)
                        pending_steps.delete(0);
                  end
               endcase
            end
         end
         start  <= nx_start;
         csr_we <= nx_we;
      end
   end

   // monitor: every strobe must match the oldest expected record
   always @(posedge clock) begin : check_p
      release_type want;
      if (!reset && rsp_valid) begin
         if (expected_releases.size() == 0) begin
            $error("unexpected word: group_id_out %h position_out %h tag_out %h last %b",
                   rsp_group_id_out, rsp_position_out, rsp_tag_out, rsp_last);
            errors++;
         end else begin
            want = expected_releases[0];
            expected_releases.delete(0);
            if (rsp_group_id_out !== want.rec.grp) begin
               $error("group_id_out: expected %h, got %h", want.rec.grp, rsp_group_id_out);
               errors++;
            end
            if (rsp_position_out !== want.rec.pos) begin
               $error("position_out: expected %h, got %h", want.rec.pos, rsp_position_out);
               errors++;
            end
            if (rsp_tag_out !== want.rec.tag) begin
               $error("tag_out: expected %h, got %h", want.rec.tag, rsp_tag_out);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   initial begin : stimulus_p
      logic [wsrb_pkg::WINDOW_W-1:0] windows [6];
      logic [wsrb_pkg::GRP_W-1:0]    run_grp;
      logic [wsrb_pkg::POS_W-1:0]    base;
      logic [wsrb_pkg::POS_W-1:0]    npos;
      int                            phase_items;
      int                            len;
      int                            spread;
      int                            r;
      logic                          force_long;

      // directed: stability, zero key, extremes, group change, flush
      add_window(31'd10);
      add_word(wsrb_pkg::ACT_FLUSH, 16'h0001, 31'd5, 32'h0);            // flush of empty
      add_word(wsrb_pkg::ACT_INSERT, 16'h0001, 31'd100, 32'hA0A0_0001); // into empty
      add_word(wsrb_pkg::ACT_INSERT, 16'h0001, 31'd100, 32'hA0A0_0002); // equal key
      add_word(wsrb_pkg::ACT_INSERT, 16'h0001, 31'd95, 32'hA0A0_0003);
      add_word(wsrb_pkg::ACT_INSERT, 16'h0001, 31'd0, 32'hA0A0_0004);   // zero key
      add_word(wsrb_pkg::ACT_INSERT, 16'h0001, 31'd130, 32'hA0A0_0005); // all but newest
      add_word(wsrb_pkg::ACT_INSERT, 16'h0002, 31'd7, 32'hA0A0_0006);   // group change
      add_word(wsrb_pkg::ACT_FLUSH, 16'hFFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
      add_word(wsrb_pkg::ACT_INSERT, 16'hFFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
      add_word(wsrb_pkg::ACT_INSERT, 16'hFFFF, 31'd1, 32'h0000_0000);
      add_word(wsrb_pkg::ACT_INSERT, 16'hFFFF, 31'h7FFF_FFFF, 32'h5555_5555);
      add_word(wsrb_pkg::ACT_INSERT, 16'h0000, 31'd1, 32'hAAAA_AAAA);
      add_word(wsrb_pkg::ACT_FLUSH, 16'h0000, 31'd0, 32'h0);
      add_drain();
      add_window(31'h7FFF_FFFF);
      add_word(wsrb_pkg::ACT_INSERT, 16'h0000, 31'd5, 32'h0000_0011);
      add_word(wsrb_pkg::ACT_INSERT, 16'h0000, 31'd3, 32'h0000_0012);
      add_word(wsrb_pkg::ACT_INSERT, 16'h0000, 31'd0, 32'h0000_0013);   // below floor
      add_word(wsrb_pkg::ACT_FLUSH, 16'h1234, 31'd9, 32'h1);
      add_window(31'd0);
      add_word(wsrb_pkg::ACT_INSERT, 16'h0003, 31'd50, 32'h0000_0021);
      add_word(wsrb_pkg::ACT_INSERT, 16'h0003, 31'd40, 32'h0000_0022);
      add_word(wsrb_pkg::ACT_INSERT, 16'h0003, 31'd60, 32'h0000_0023);
      add_word(wsrb_pkg::ACT_FLUSH, 16'h0003, 31'd60, 32'h0);

      // random phases, one window setting each
      windows[0] = 31'd0;
      windows[1] = 31'd1;
      windows[2] = 31'd25;
      windows[3] = 31'd1000;
      windows[4] = 31'h7FFF_FFFF;
      windows[5] = wsrb_pkg::WINDOW_W'($urandom);
      run_grp = wsrb_pkg::GRP_W'($urandom_range(0, 65535));
      foreach (windows[k]) begin
         add_window(windows[k]);
         force_long  = (k == 4);   // wide window: fill the buffer to overflow
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               add_word(wsrb_pkg::ACT_FLUSH, wsrb_pkg::GRP_W'($urandom),
                        wsrb_pkg::POS_W'($urandom), $urandom);
               phase_items++;
            end else if (r < 13) begin
               case ($urandom_range(0, 3))
                  0:       npos = '0;
                  1:       npos = 31'h7FFF_FFFF;
                  default: npos = wsrb_pkg::POS_W'($urandom);
               endcase
               add_word(wsrb_pkg::ACT_INSERT, wsrb_pkg::GRP_W'($urandom_range(0, 65535)),
                        npos, $urandom);
               phase_items++;
            end else if (r < 15) begin
               add_drain();
            end else begin
               if (r < 32)
                  run_grp = wsrb_pkg::GRP_W'($urandom_range(0, 65535));
               if (force_long) begin
                  len        = 36;
                  force_long = 1'b0;
               end else begin
                  if ($urandom_range(0, 7) == 0)
                     len = $urandom_range(33, 40);
                  else
                     len = $urandom_range(1, 10);
                  if (len > PHASE_ITEMS - phase_items)
                     len = PHASE_ITEMS - phase_items;
               end
               if ($urandom_range(0, 3) == 0)
                  base = wsrb_pkg::POS_W'($urandom_range(1, 32'h7FFF_0000));
               else
                  base = wsrb_pkg::POS_W'($urandom_range(1, 2000));
               spread = $urandom_range(0, 600);
               repeat (len) begin
                  add_word(wsrb_pkg::ACT_INSERT, run_grp,
                           base + wsrb_pkg::POS_W'($urandom_range(0, spread)), $urandom);
                  base = base + wsrb_pkg::POS_W'($urandom_range(0, 40));
                  phase_items++;
               end
            end
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_steps.size() != 0 || start || busy || expected_releases.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_releases.size() != 0) begin
         $error("%0d expected words never arrived", expected_releases.size());
         errors++;
      end
      if (errors == 0)
         $display("tb_windowed_sort_release_buffer_core OK");
      else
         $display("tb_windowed_sort_release_buffer_core NOT OK");
      $finish;
   end

   initial begin : watchdog_p
      #2000000;
      $display("tb_windowed_sort_release_buffer_core NOT OK");
      $finish;
   end

endmodule
